[hdl/dtsp_pkg.sv]
// Shared types and constants for the device tree structure block parser.
// Used by dtsp_front, dtsp_queue, dtsp_back and the top level.
`default_nettype none

package dtsp_pkg;

  localparam logic [31:0] BLOB_MAGIC        = 32'hd00dfeed;
  localparam logic [31:0] SUPPORTED_VERSION = 32'd17;

  // structure block token words
  localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [31:0] TOK_END_NODE   = 32'd2;
  localparam logic [31:0] TOK_PROP       = 32'd3;
  localparam logic [31:0] TOK_NOP        = 32'd4;
  localparam logic [31:0] TOK_END        = 32'd9;

  // config register indexes
  localparam logic [1:0] REG_STRUCT_SIZE = 2'd0;
  localparam logic [1:0] REG_MAGIC       = 2'd1;
  localparam logic [1:0] REG_LAST_COMP   = 2'd2;

  // queue between front and back
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef enum logic [2:0] {
    TK_BEGIN_NODE,
    TK_END_NODE,
    TK_PROP,
    TK_NOP,
    TK_END,
    TK_BAD
  } tok_class_t;

  typedef enum logic [2:0] {
    EV_BEGIN = 3'd0,
    EV_END   = 3'd1,
    EV_PROP  = 3'd2,
    EV_DONE  = 3'd3,
    EV_ERROR = 3'd4
  } event_t;

  typedef enum logic [5:0] {
    PH_STOPPED = 6'b000001,
    PH_TOKEN   = 6'b000010,
    PH_NAME    = 6'b000100,
    PH_PLEN    = 6'b001000,
    PH_POFF    = 6'b010000,
    PH_SKIP    = 6'b100000
  } phase_t;

  // one classified word as it travels through the queue
  typedef struct packed {
    logic [31:0] word;
    logic        first;
    tok_class_t  tok;
    logic        nul;        // some byte of the word is zero
    logic [32:0] round_len;  // word taken as a length, rounded up to 4
  } q_entry_t;

endpackage

`default_nettype wire

[hdl/dtsp_front.sv]
// Front end: classifies each incoming structure word (token kind, NUL byte,
// rounded length). Depends on dtsp_pkg.
`default_nettype none

module dtsp_front
  import dtsp_pkg::*;
(
  input  wire logic [31:0] word,
  input  wire logic        first,
  output q_entry_t         entry
);

  tok_class_t  tok;
  logic [30:0] words;

  always_comb begin
    unique case (word)
      TOK_BEGIN_NODE: tok = TK_BEGIN_NODE;
      TOK_END_NODE:   tok = TK_END_NODE;
      TOK_PROP:       tok = TK_PROP;
      TOK_NOP:        tok = TK_NOP;
      TOK_END:        tok = TK_END;
      default:        tok = TK_BAD;
    endcase
  end

  assign words = {1'b0, word[31:2]} + 31'(|word[1:0]);

  assign entry.word      = word;
  assign entry.first     = first;
  assign entry.tok       = tok;
  assign entry.nul       = (word[31:24] == 8'd0) || (word[23:16] == 8'd0) ||
                           (word[15:8] == 8'd0) || (word[7:0] == 8'd0);
  assign entry.round_len = {words, 2'b00};

endmodule

`default_nettype wire

[hdl/dtsp_queue.sv]
// Small register queue between the classifier and the walker.
// Depends on dtsp_pkg.
`default_nettype none

module dtsp_queue
  import dtsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  q_entry_t  in_entry,
  output logic      out_valid,
  input  wire logic out_ready,
  output q_entry_t  out_entry
);

  q_entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic                  push;
  logic                  pop;

  assign in_ready  = (count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/dtsp_back.sv]
// Back end: header check, token walk, depth/offset tracking, config
// registers and the result register. Depends on dtsp_pkg.
`default_nettype none

module dtsp_back
  import dtsp_pkg::*;
#(
  parameter int MAX_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  q_entry_t         q_entry,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [2:0]       event_res,
  output logic [5:0]       depth,
  output logic [31:0]      prop_length,
  output logic [31:0]      name_offset,
  output logic [31:0]      byte_offset
);

  localparam int DW = $clog2(MAX_DEPTH) + 1;

  logic [31:0] struct_size;
  logic [31:0] header_magic;
  logic [31:0] min_reader_version;

  phase_t             phase, phase_next;
  logic signed [DW-1:0] node_depth, depth_next;
  logic [31:0]        offset, offset_next;
  logic [29:0]        skip_count, skip_next;
  logic [31:0]        held_length, held_next;
  logic [32:0]        held_round, round_next;

  phase_t             cur_phase;
  logic signed [DW-1:0] cur_depth;
  logic [31:0]        cur_offset;
  logic               hdr_ok;
  logic [32:0]        off4;
  logic               overrun;
  logic [33:0]        prop_end;
  logic               fire;
  logic               emit;
  event_t             ev;
  logic [31:0]        ev_plen;
  logic [31:0]        ev_noff;
  logic [31:0]        ev_boff;

  assign q_ready = !res_valid || res_ready;
  assign fire    = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      struct_size        <= '0;
      header_magic       <= '0;
      min_reader_version <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_STRUCT_SIZE: struct_size        <= cfg_wdata;
        REG_MAGIC:       header_magic       <= cfg_wdata;
        REG_LAST_COMP:   min_reader_version <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  assign hdr_ok     = (header_magic == BLOB_MAGIC) &&
                      (min_reader_version <= SUPPORTED_VERSION);
  assign cur_phase  = q_entry.first ? PH_TOKEN : phase;
  assign cur_depth  = q_entry.first ? '1 : node_depth;
  assign cur_offset = q_entry.first ? '0 : offset;
  assign off4       = {1'b0, cur_offset} + 33'd4;
  assign overrun    = off4 > {1'b0, struct_size};
  assign prop_end   = {1'b0, off4} + {1'b0, held_round};

  always_comb begin
    phase_next  = cur_phase;
    depth_next  = cur_depth;
    offset_next = cur_offset;
    skip_next   = skip_count;
    held_next   = held_length;
    round_next  = held_round;
    emit        = 1'b0;
    ev          = EV_ERROR;
    ev_plen     = '0;
    ev_noff     = '0;
    ev_boff     = off4[31:0];

    priority if (q_entry.first && !hdr_ok) begin
      phase_next = PH_STOPPED;
      emit       = 1'b1;
      ev_boff    = 32'd4;
    end else if (cur_phase == PH_STOPPED) begin
      phase_next = PH_STOPPED;
    end else if (overrun) begin
      phase_next = PH_STOPPED;
      emit       = 1'b1;
    end else begin
      offset_next = off4[31:0];
      unique case (cur_phase)
        PH_TOKEN: begin
          unique case (q_entry.tok)
            TK_BEGIN_NODE: phase_next = PH_NAME;
            TK_PROP:       phase_next = PH_PLEN;
            TK_NOP:        ;
            TK_END_NODE: begin
              emit = 1'b1;
              if (cur_depth == '1) begin
                phase_next = PH_STOPPED;
              end else begin
                depth_next = cur_depth - 1'b1;
                ev         = EV_END;
              end
            end
            TK_END: begin
              phase_next = PH_STOPPED;
              emit       = 1'b1;
              ev         = EV_DONE;
            end
            default: begin
              phase_next = PH_STOPPED;
              emit       = 1'b1;
            end
          endcase
        end
        PH_NAME: begin
          if (q_entry.nul) begin
            emit = 1'b1;
            if (cur_depth == DW'(MAX_DEPTH - 1)) begin
              phase_next = PH_STOPPED;
            end else begin
              depth_next = cur_depth + 1'b1;
              phase_next = PH_TOKEN;
              ev         = EV_BEGIN;
            end
          end
        end
        PH_PLEN: begin
          held_next  = q_entry.word;
          round_next = q_entry.round_len;
          phase_next = PH_POFF;
        end
        PH_POFF: begin
          emit = 1'b1;
          if (prop_end > {2'b00, struct_size}) begin
            phase_next = PH_STOPPED;
          end else begin
            ev         = EV_PROP;
            ev_plen    = held_length;
            ev_noff    = q_entry.word;
            skip_next  = held_round[31:2];
            phase_next = (held_round[32:2] != '0) ? PH_SKIP : PH_TOKEN;
          end
        end
        PH_SKIP: begin
          skip_next = skip_count - 1'b1;
          if (skip_count == 30'd1) begin
            phase_next = PH_TOKEN;
          end
        end
        default: phase_next = PH_STOPPED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_STOPPED;
      node_depth  <= '1;
      offset      <= '0;
      skip_count  <= '0;
      held_length <= '0;
      held_round  <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (fire) begin
        phase       <= phase_next;
        node_depth  <= depth_next;
        offset      <= offset_next;
        skip_count  <= skip_next;
        held_length <= held_next;
        held_round  <= round_next;
      end
      if (fire && emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      event_res   <= ev;
      depth       <= 6'(depth_next);
      prop_length <= ev_plen;
      name_offset <= ev_noff;
      byte_offset <= ev_boff;
    end
  end

`ifndef NO_ASSERTIONS
  a_stop_after_final: assert property (@(posedge clk) disable iff (rst)
    fire && emit && (ev == EV_ERROR || ev == EV_DONE) |=> phase == PH_STOPPED)
    else $error("walker still running after done or error");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    node_depth <= $signed(DW'(MAX_DEPTH - 1)))
    else $error("node depth past limit");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_count != '0)
    else $error("skip phase with nothing left to skip");

  a_offset_aligned: assert property (@(posedge clk) disable iff (rst)
    offset[1:0] == 2'b00)
    else $error("byte offset not word aligned");
`endif

endmodule

`default_nettype wire

[hdl/devicetree_struct_block_parser.sv]
// Top level of the flattened device tree structure block parser.
// Depends on dtsp_pkg, dtsp_front, dtsp_queue and dtsp_back.
// Input channel (in_valid/in_ready): one 32-bit structure block word per
//   transaction, first byte in bits 31:24; first=1 starts a new walk and
//   checks the header registers (magic, last compatible version <= 17).
// Result channel (res_valid/res_ready): at most one event per word: node
//   begin, node end, property, done or error, with the depth after the
//   event, property length, name offset and the byte offset just past it.
// Config port: cfg_wen writes cfg_wdata into register cfg_index
//   (0 struct size, 1 header magic, 2 oldest compatible reader version);
//   write only while no word is in flight.
// Path: an accepted word is first registered in the queue; the walker steps
//   it from the queue head and loads the result register, which offers
//   its event. One word per cycle is sustained while res_ready is high.
// Stalls: while res_ready is low the walker holds once the result
//   register is full; the four-entry queue keeps accepting until it fills.
// Reset: rst (synchronous) clears the queue, the result register, the
//   config registers and stops the walk (depth -1, offset 0).
`default_nettype none

module devicetree_struct_block_parser
  import dtsp_pkg::*;
#(
  parameter int MAX_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] word,
  input  wire logic        first,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [2:0]       event_res,
  output logic [5:0]       depth,
  output logic [31:0]      prop_length,
  output logic [31:0]      name_offset,
  output logic [31:0]      byte_offset
);

  q_entry_t in_entry;
  q_entry_t q_entry;
  logic     q_valid;
  logic     q_ready;

  // classify the incoming word
  dtsp_front u_front (
    .word  (word),
    .first (first),
    .entry (in_entry)
  );

  // decouples input acceptance from walker stalls
  dtsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_entry  (in_entry),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_entry (q_entry)
  );

  // walker and result register
  dtsp_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_entry     (q_entry),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .event_res   (event_res),
    .depth       (depth),
    .prop_length (prop_length),
    .name_offset (name_offset),
    .byte_offset (byte_offset)
  );

endmodule

`default_nettype wire
